### src/worst_fit_partition_allocator_macros.svh
// Assertion macros for the worst-fit partition allocator.
// Used by the controller and datapath; expects clk_i and rst_ni in scope.
`ifndef WORST_FIT_PARTITION_ALLOCATOR_MACROS_SVH
`define WORST_FIT_PARTITION_ALLOCATOR_MACROS_SVH

// check a property on every rising clock edge outside reset
`define WFPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that a condition never holds
`define WFPA_ASSERT_NEVER(name, expr, msg) \
  `WFPA_ASSERT(name, !(expr), msg)

`endif

### src/wfpa_pkg.sv
// Package for the worst-fit partition allocator: sizes, word types, codes.
// No dependencies.
package wfpa_pkg;

  localparam int unsigned MAX_PARTITIONS = 16;
  localparam int unsigned SIZE_BITS      = 16;

  localparam int unsigned IDX_W    = $clog2(MAX_PARTITIONS);
  localparam int unsigned CNT_W    = $clog2(MAX_PARTITIONS + 1);
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned NUM_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REQ = 2'd1;
  localparam int unsigned MODE_CLR_BIT   = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_GRANTED = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } ctrl_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] size;
  } req_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    partition_number;
    logic [SIZE_W-1:0]   space_left;
  } rsp_word_t;

  typedef struct packed {
    logic add;
    logic req;
    logic clr;
    logic scan;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

  function automatic logic [SIZE_BITS-1:0] size_from_word(input logic [SIZE_W-1:0] w);
    logic [SIZE_BITS+SIZE_W-1:0] tmp;
    tmp = {{SIZE_BITS{1'b0}}, w};
    return tmp[SIZE_BITS-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] size_to_word(input logic [SIZE_BITS-1:0] s);
    logic [SIZE_BITS+SIZE_W-1:0] tmp;
    tmp = {{SIZE_W{1'b0}}, s};
    return tmp[SIZE_W-1:0];
  endfunction

  function automatic logic [NUM_W-1:0] idx_to_num(input logic [IDX_W-1:0] idx);
    logic [IDX_W+NUM_W-1:0] tmp;
    tmp = {{NUM_W{1'b0}}, idx};
    return tmp[NUM_W-1:0];
  endfunction

endpackage

### src/wfpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfpa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/wfpa_ctrl.sv
// Controller state machine for the worst-fit partition allocator.
// Depends on wfpa_pkg and worst_fit_partition_allocator_macros.svh.
`include "worst_fit_partition_allocator_macros.svh"

module wfpa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [wfpa_pkg::MODE_W-1:0] mode_i,
  input  wfpa_pkg::stat_t       stat_i,
  output wfpa_pkg::cmd_t        cmd_o,
  output logic                  busy_o
);

  wfpa_pkg::ctrl_state_e state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == wfpa_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wfpa_pkg::S_IDLE: begin
        if (accept && !mode_i[wfpa_pkg::MODE_CLR_BIT] && (mode_i == wfpa_pkg::MODE_REQ)) begin
          state_d = wfpa_pkg::S_SCAN;
        end
      end
      wfpa_pkg::S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = wfpa_pkg::S_DECIDE;
        end
      end
      wfpa_pkg::S_DECIDE: begin
        state_d = wfpa_pkg::S_IDLE;
      end
      default: begin
        state_d = wfpa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      wfpa_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (accept) begin
          if (mode_i[wfpa_pkg::MODE_CLR_BIT]) begin
            cmd_o.clr = 1'b1;
          end else if (mode_i == wfpa_pkg::MODE_REQ) begin
            cmd_o.req = 1'b1;
          end else begin
            cmd_o.add = 1'b1;
          end
        end
      end
      wfpa_pkg::S_SCAN: begin
        cmd_o.scan = !stat_i.scan_done;
      end
      wfpa_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wfpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `WFPA_ASSERT(a_decide_once, (state_q == wfpa_pkg::S_DECIDE) |=> (state_q == wfpa_pkg::S_IDLE), "decide state held")
  `WFPA_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one command issued")
  `WFPA_ASSERT(a_req_scans, cmd_o.req |=> (state_q == wfpa_pkg::S_SCAN), "request did not start a scan")
  `WFPA_ASSERT_NEVER(a_busy_accept, busy_o && (cmd_o.add || cmd_o.req || cmd_o.clr), "word taken while busy")

endmodule

### src/wfpa_dp.sv
// Datapath of the worst-fit partition allocator: table, scan, result register.
// Depends on wfpa_pkg, wfpa_ram and worst_fit_partition_allocator_macros.svh.
`include "worst_fit_partition_allocator_macros.svh"

module wfpa_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wfpa_pkg::req_word_t   req_i,
  input  wfpa_pkg::cmd_t        cmd_i,
  output wfpa_pkg::stat_t       stat_o,
  output logic                  valid_o,
  output wfpa_pkg::rsp_word_t   rsp_o
);

  localparam logic [wfpa_pkg::CNT_W-1:0] MaxCnt = wfpa_pkg::CNT_W'(wfpa_pkg::MAX_PARTITIONS);

  logic [wfpa_pkg::CNT_W-1:0]          count_q, count_d;
  logic [wfpa_pkg::MAX_PARTITIONS-1:0] used_q, used_d;
  logic [wfpa_pkg::CNT_W-1:0]          idx_q, idx_d;
  logic                                pend_q, pend_d;
  logic [wfpa_pkg::IDX_W-1:0]          pend_idx_q, pend_idx_d;
  logic                                found_q, found_d;
  logic [wfpa_pkg::IDX_W-1:0]          best_q, best_d;
  logic [wfpa_pkg::SIZE_BITS-1:0]      best_size_q, best_size_d;
  logic [wfpa_pkg::SIZE_BITS-1:0]      sz_q, sz_d;
  logic                                valid_q, valid_d;
  wfpa_pkg::rsp_word_t                 rsp_q, rsp_d;

  logic                                we;
  logic [wfpa_pkg::IDX_W-1:0]          waddr;
  logic [wfpa_pkg::SIZE_BITS-1:0]      wdata;
  logic [wfpa_pkg::SIZE_BITS-1:0]      rdata;
  logic [wfpa_pkg::SIZE_BITS-1:0]      left;
  logic                                full;
  logic                                better;
  logic                                fit;

  wfpa_ram #(
    .WIDTH(wfpa_pkg::SIZE_BITS),
    .DEPTH(wfpa_pkg::MAX_PARTITIONS)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_q[wfpa_pkg::IDX_W-1:0]),
    .rdata_o(rdata)
  );

  assign full   = (count_q == MaxCnt);
  assign better = pend_q && !used_q[pend_idx_q] && (!found_q || (rdata > best_size_q));
  assign fit    = found_q && (best_size_q >= sz_q);
  assign left   = best_size_q - sz_q;
  assign stat_o.scan_done = (idx_q == count_q) && !pend_q;

  always_comb begin
    count_d     = count_q;
    used_d      = used_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    best_d      = best_q;
    best_size_d = best_size_q;
    sz_d        = sz_q;
    valid_d     = 1'b0;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = count_q[wfpa_pkg::IDX_W-1:0];
    wdata       = wfpa_pkg::size_from_word(req_i.size);

    if (cmd_i.clr) begin
      count_d = '0;
      used_d  = '0;
      valid_d = 1'b1;
      rsp_d   = '{status: wfpa_pkg::ST_CLEARED, partition_number: '0, space_left: '0};
    end

    if (cmd_i.add) begin
      valid_d = 1'b1;
      if (full) begin
        rsp_d = '{status: wfpa_pkg::ST_FULL, partition_number: '0, space_left: '0};
      end else begin
        we = 1'b1;
        used_d[count_q[wfpa_pkg::IDX_W-1:0]] = 1'b0;
        count_d = count_q + 1'b1;
        rsp_d   = '{status: wfpa_pkg::ST_ADDED,
                    partition_number: wfpa_pkg::idx_to_num(count_q[wfpa_pkg::IDX_W-1:0]),
                    space_left: '0};
      end
    end

    if (cmd_i.req) begin
      sz_d    = wfpa_pkg::size_from_word(req_i.size);
      idx_d   = '0;
      pend_d  = 1'b0;
      found_d = 1'b0;
    end

    if (cmd_i.scan) begin
      if (idx_q != count_q) begin
        idx_d      = idx_q + 1'b1;
        pend_d     = 1'b1;
        pend_idx_d = idx_q[wfpa_pkg::IDX_W-1:0];
      end else begin
        pend_d = 1'b0;
      end
      if (better) begin
        found_d     = 1'b1;
        best_d      = pend_idx_q;
        best_size_d = rdata;
      end
    end

    if (cmd_i.decide) begin
      valid_d = 1'b1;
      if (fit) begin
        we           = 1'b1;
        waddr        = best_q;
        wdata        = left;
        used_d[best_q] = 1'b1;
        rsp_d = '{status: wfpa_pkg::ST_GRANTED,
                  partition_number: wfpa_pkg::idx_to_num(best_q),
                  space_left: wfpa_pkg::size_to_word(left)};
      end else begin
        rsp_d = '{status: wfpa_pkg::ST_NOFIT, partition_number: '0, space_left: '0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      used_q  <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    best_q      <= best_d;
    best_size_q <= best_size_d;
    sz_q        <= sz_d;
    rsp_q       <= rsp_d;
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `WFPA_ASSERT(a_count_range, count_q <= MaxCnt, "partition count beyond table")
  `WFPA_ASSERT(a_grant_marks, (cmd_i.decide && fit) |=> used_q[$past(best_q)], "granted partition not marked used")
  `WFPA_ASSERT(a_pend_in_table, pend_q |-> ({1'b0, pend_idx_q} < count_q), "scan read beyond table")

endmodule

### src/worst_fit_partition_allocator.sv
// Worst-fit fixed-partition allocator: top level joining controller and datapath.
// Add and clear words give their result in the cycle after acceptance; a request first
// scans the table in S_SCAN, one RAM entry a cycle over the partitions in the table, then
// decides in S_DECIDE and registers the response together with the result strobe.
// busy is low again in the cycle the result strobe is high; results cannot be stalled.
// Reset empties the table and clears all used flags; stored sizes are not cleared.
module worst_fit_partition_allocator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  wfpa_pkg::req_word_t req_i,
  output logic                valid_o,
  output wfpa_pkg::rsp_word_t rsp_o
);

  wfpa_pkg::cmd_t  cmd;
  wfpa_pkg::stat_t stat;

  wfpa_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .mode_i(req_i.mode),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy_o(busy)
  );

  wfpa_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

endmodule
